FILE: rtl/pm_pkg.sv
// Shared types and constants for the polynomial multiplier.
// No dependencies; used by pm_ctrl, pm_datapath and polynomial_multiplier_top.
`default_nettype none

package pm_pkg;

    // Term limit per operand and derived widths
    localparam int MAX_TERMS = 32;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int POW_W     = 6;
    localparam int COEF_W    = 32;

    // Operand select codes on the command field
    localparam logic CMD_LEFT  = 1'b0;
    localparam logic CMD_RIGHT = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } pm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // transfer of one input coefficient
        logic init_k;  // set up the pair range for the current power
        logic issue;   // read one term pair into the MAC pipeline
        logic emit;    // present the accumulated coefficient
        logic clear;   // drop both operands after the final coefficient
    } pm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic both_done;   // both operands complete
        logic last_pair;   // current issue is the last pair of this power
        logic pipe_empty;  // no pair in flight in the MAC pipeline
        logic k_last;      // current power is the highest one
    } pm_status_t;

endpackage

`default_nettype wire

FILE: rtl/pm_ctrl.sv
// Controller state machine for the polynomial multiplier.
// Depends on pm_pkg for the state type and the command and status structs.
`default_nettype none

module pm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pm_pkg::pm_status_t status,
    output pm_pkg::pm_cmd_t         cmd
);

    pm_pkg::pm_state_t state_reg;
    pm_pkg::pm_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the per-power MAC sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pm_pkg::ST_IDLE:
            begin
                if (status.both_done)
                begin
                    state_next = pm_pkg::ST_INIT;
                end
            end
            pm_pkg::ST_INIT:
            begin
                state_next = pm_pkg::ST_ISSUE;
            end
            pm_pkg::ST_ISSUE:
            begin
                if (status.last_pair)
                begin
                    state_next = pm_pkg::ST_DRAIN;
                end
            end
            pm_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = pm_pkg::ST_EMIT;
                end
            end
            pm_pkg::ST_EMIT:
            begin
                if (status.k_last)
                begin
                    state_next = pm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = pm_pkg::ST_INIT;
                end
            end
            default:
            begin
                state_next = pm_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive commands and busy from the state
    always_comb
    begin
        busy        = (state_reg != pm_pkg::ST_IDLE) || status.both_done;
        cmd         = '0;
        cmd.load    = start && !busy;
        cmd.init_k  = (state_reg == pm_pkg::ST_INIT);
        cmd.issue   = (state_reg == pm_pkg::ST_ISSUE);
        cmd.emit    = (state_reg == pm_pkg::ST_EMIT);
        cmd.clear   = (state_reg == pm_pkg::ST_EMIT) && status.k_last;
    end

endmodule

`default_nettype wire

FILE: rtl/pm_datapath.sv
// Datapath of the polynomial multiplier: operand memories, counters,
// pipelined multiply-accumulate and result registers. Depends on pm_pkg.
`default_nettype none

module pm_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pm_pkg::pm_cmd_t               cmd,
    output pm_pkg::pm_status_t                 status,
    input  wire logic                          command,
    input  wire logic [pm_pkg::COEF_W-1:0]     coeff_in,
    input  wire logic                          end_of_operand,
    output logic                               done,
    output logic [pm_pkg::POW_W-1:0]           power,
    output logic [pm_pkg::COEF_W-1:0]          coeff_out,
    output logic                               final_term,
    output logic                               truncated
);

    // Operand memories
    logic [pm_pkg::COEF_W-1:0] left_mem  [pm_pkg::MAX_TERMS];
    logic [pm_pkg::COEF_W-1:0] right_mem [pm_pkg::MAX_TERMS];

    // Operand bookkeeping
    logic [pm_pkg::CNT_W-1:0] lcount_reg, lcount_next;
    logic [pm_pkg::CNT_W-1:0] rcount_reg, rcount_next;
    logic                     lcomp_reg, lcomp_next;
    logic                     rcomp_reg, rcomp_next;
    logic                     ovf_reg, ovf_next;
    logic                     lwrite, rwrite;

    // Sequencing
    logic [pm_pkg::POW_W-1:0] k_reg;
    logic [pm_pkg::IDX_W-1:0] i_reg;
    logic [pm_pkg::IDX_W-1:0] i_hi_reg;
    logic [pm_pkg::IDX_W-1:0] i_lo;
    logic [pm_pkg::IDX_W-1:0] i_hi;
    logic [pm_pkg::IDX_W-1:0] j_idx;
    logic [pm_pkg::POW_W-1:0] kp1;
    logic [pm_pkg::POW_W-1:0] k_minus_i;
    logic [pm_pkg::POW_W:0]   k_plus2;
    logic [pm_pkg::POW_W:0]   count_sum;

    // MAC pipeline
    logic                        v1_reg, v2_reg;
    logic [pm_pkg::COEF_W-1:0]   ldata_reg, rdata_reg;
    logic [2*pm_pkg::COEF_W-1:0] mul_full;
    logic [pm_pkg::COEF_W-1:0]   prod_reg;
    logic [pm_pkg::COEF_W-1:0]   acc_reg;

    // Result registers
    logic                        done_reg;
    logic [pm_pkg::POW_W-1:0]    power_reg;
    logic [pm_pkg::COEF_W-1:0]   coeff_reg;
    logic                        final_reg;
    logic                        trunc_reg;

    // Take one coefficient: store below the limit, flag beyond it; clear empties both operands
    always_comb
    begin
        lcount_next = lcount_reg;
        rcount_next = rcount_reg;
        lcomp_next  = lcomp_reg;
        rcomp_next  = rcomp_reg;
        ovf_next    = ovf_reg;
        lwrite      = 1'b0;
        rwrite      = 1'b0;
        if (cmd.clear)
        begin
            lcount_next = '0;
            rcount_next = '0;
            lcomp_next  = 1'b0;
            rcomp_next  = 1'b0;
            ovf_next    = 1'b0;
        end
        else if (cmd.load)
        begin
            if (command == pm_pkg::CMD_RIGHT)
            begin
                if (!rcomp_reg)
                begin
                    if (rcount_reg < pm_pkg::CNT_W'(pm_pkg::MAX_TERMS))
                    begin
                        rwrite      = 1'b1;
                        rcount_next = rcount_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    rcomp_next = end_of_operand;
                end
            end
            else
            begin
                if (!lcomp_reg)
                begin
                    if (lcount_reg < pm_pkg::CNT_W'(pm_pkg::MAX_TERMS))
                    begin
                        lwrite      = 1'b1;
                        lcount_next = lcount_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    lcomp_next = end_of_operand;
                end
            end
        end
    end

    // Pair range for power k: max(0, k-lb+1) up to min(k, la-1)
    always_comb
    begin
        kp1       = k_reg + 1'b1;
        k_minus_i = k_reg - pm_pkg::POW_W'(i_reg);
        j_idx     = k_minus_i[pm_pkg::IDX_W-1:0];
        if (kp1 >= pm_pkg::POW_W'(rcount_reg))
        begin
            i_lo = pm_pkg::IDX_W'(kp1 - pm_pkg::POW_W'(rcount_reg));
        end
        else
        begin
            i_lo = '0;
        end
        if (k_reg < pm_pkg::POW_W'(lcount_reg))
        begin
            i_hi = k_reg[pm_pkg::IDX_W-1:0];
        end
        else
        begin
            i_hi = pm_pkg::IDX_W'(lcount_reg - 1'b1);
        end
        k_plus2   = {1'b0, k_reg} + (pm_pkg::POW_W+1)'(2);
        count_sum = (pm_pkg::POW_W+1)'(lcount_reg) + (pm_pkg::POW_W+1)'(rcount_reg);
    end

    assign mul_full = ldata_reg * rdata_reg;

    // Hold operand bookkeeping, sequencing and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcount_reg <= '0;
            rcount_reg <= '0;
            lcomp_reg  <= 1'b0;
            rcomp_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
            i_reg      <= '0;
            i_hi_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            lcount_reg <= lcount_next;
            rcount_reg <= rcount_next;
            lcomp_reg  <= lcomp_next;
            rcomp_reg  <= rcomp_next;
            ovf_reg    <= ovf_next;
            v1_reg     <= cmd.issue;
            v2_reg     <= v1_reg;
            done_reg   <= cmd.emit;
            if (cmd.init_k)
            begin
                i_reg    <= i_lo;
                i_hi_reg <= i_hi;
            end
            else if (cmd.issue)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                k_reg <= '0;
            end
            else if (cmd.emit)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Write and read the operand memories
    always_ff @(posedge clk)
    begin
        if (lwrite)
        begin
            left_mem[lcount_reg[pm_pkg::IDX_W-1:0]] <= coeff_in;
        end
        if (rwrite)
        begin
            right_mem[rcount_reg[pm_pkg::IDX_W-1:0]] <= coeff_in;
        end
        ldata_reg <= left_mem[i_reg];
        rdata_reg <= right_mem[j_idx];
    end

    // Multiply, accumulate modulo 2^32 and capture the result
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[pm_pkg::COEF_W-1:0];
        if (cmd.init_k)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.emit)
        begin
            power_reg <= k_reg;
            coeff_reg <= acc_reg;
            final_reg <= (k_plus2 == count_sum);
            trunc_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        status.both_done  = lcomp_reg && rcomp_reg;
        status.last_pair  = (i_reg == i_hi_reg);
        status.pipe_empty = !v1_reg && !v2_reg;
        status.k_last     = (k_plus2 == count_sum);
    end

    assign done       = done_reg;
    assign power      = power_reg;
    assign coeff_out  = coeff_reg;
    assign final_term = final_reg;
    assign truncated  = trunc_reg;

    // Issued pairs stay inside the range of the current power
    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (i_reg <= i_hi_reg))
        else $error("pair index past upper bound");

    // Counts never pass the term limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (lcount_reg <= pm_pkg::CNT_W'(pm_pkg::MAX_TERMS))
        && (rcount_reg <= pm_pkg::CNT_W'(pm_pkg::MAX_TERMS)))
        else $error("operand count past term limit");

    // A coefficient is emitted only after the MAC pipeline drained
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!v1_reg && !v2_reg))
        else $error("emit with pairs in flight");

    // Results never come in adjacent cycles
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("back-to-back result strobes");

    // No coefficient transfer while a product is being computed
    a_no_load_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.issue && !v1_reg && !v2_reg && !status.both_done))
        else $error("coefficient transfer during product");

endmodule

`default_nettype wire

FILE: rtl/polynomial_multiplier_top.sv
// Top level of the polynomial multiplier: joins pm_ctrl and pm_datapath.
// Depends on pm_pkg, pm_ctrl and pm_datapath.
//
// Channel   | Ports                                   | Transfer when
// ----------+-----------------------------------------+---------------------
// input     | command, coeff_in, end_of_operand       | start && !busy
// result    | power, coeff_out, final_term, truncated | done (one cycle)
//
// The transfer that completes the second operand starts the product; busy
// stays high until the final coefficient is emitted. Each product power k
// passes through setup, one issue per term pair, a drain of the read,
// multiply and accumulate registers, and emit, all on the single shared
// multiply-accumulate.
// Reset clears the counts and flags; the operand memories need no clearing.
// Results cannot be stalled: each is valid for the single cycle done is high.
`default_nettype none

module polynomial_multiplier_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      command,
    input  wire logic signed [31:0]        coeff_in,
    input  wire logic                      end_of_operand,
    output logic                           done,
    output logic [5:0]                     power,
    output logic signed [31:0]             coeff_out,
    output logic                           final_term,
    output logic                           truncated
);

    pm_pkg::pm_cmd_t           cmd;
    pm_pkg::pm_status_t        status;
    logic [pm_pkg::COEF_W-1:0] coeff_u;

    pm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    pm_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .command        (command),
        .coeff_in       ($unsigned(coeff_in)),
        .end_of_operand (end_of_operand),
        .done           (done),
        .power          (power),
        .coeff_out      (coeff_u),
        .final_term     (final_term),
        .truncated      (truncated)
    );

    assign coeff_out = $signed(coeff_u);

endmodule

`default_nettype wire
